/* sv/segment_allocator_with_compaction_unit_macros.svh */
// ----------------------------------------------------------------------------
// Segment allocator assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_ALLOCATOR_WITH_COMPACTION_UNIT_MACROS_SVH
`define SEGMENT_ALLOCATOR_WITH_COMPACTION_UNIT_MACROS_SVH

// check a property on every clock edge outside reset
`define SACU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check an implication on every clock edge outside reset
`define SACU_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

/* sv/sacu_pkg.sv */
// ----------------------------------------------------------------------------
// Segment allocator package
// Codes, defaults and the command and status types shared by the modules.
// ----------------------------------------------------------------------------
package sacu_pkg;

    localparam int STORE_BYTES_DEF  = 32;
    localparam int MAX_SEGMENTS_DEF = 16;

    localparam logic [2:0] KIND_ALLOC   = 3'd0;
    localparam logic [2:0] KIND_FREE    = 3'd1;
    localparam logic [2:0] KIND_COMPACT = 3'd2;
    localparam logic [2:0] KIND_WRITE   = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OOM      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_BAD      = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_APPEND,
        OP_TBL_RD,
        OP_NEXT_I,
        OP_REUSE,
        OP_MARK_FREE,
        OP_ZERO_SEG,
        OP_MOVE_RD,
        OP_MOVE_WR,
        OP_SKIP_BYTE,
        OP_KEEP,
        OP_TAIL_INIT,
        OP_ZERO_TAIL,
        OP_COMPACT_END,
        OP_BYTE_WR,
        OP_BYTE_RD
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       finish;
        logic [2:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       size_zero;
        logic       can_append;
        logic       fits;
        logic       i_end;
        logic       alloc_hit;
        logic       free_hit;
        logic       avail;
        logic       k_end;
        logic       move_ok;
        logic       tail_end;
        logic       addr_ok;
        logic       out_busy;
    } dp_stat_t;

endpackage

/* sv/sacu_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sacu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/sacu_ctrl.sv */
// ----------------------------------------------------------------------------
// Segment allocator controller
// Sequences table scans, byte moves and result hand-off.
// ----------------------------------------------------------------------------
module sacu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sacu_pkg::dp_stat_t stat,
    output sacu_pkg::dp_cmd_t  cmd
);
    import sacu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_CHK,
        S_ZERO,
        S_MOVE,
        S_MOVE_WR,
        S_TAIL,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] st_reg, st_next;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd.op     = OP_NONE;
        cmd.finish = 1'b0;
        cmd.status = st_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                st_next    = ST_BAD;
                priority case (stat.kind)
                    KIND_ALLOC:
                    begin
                        if (stat.size_zero)
                        begin
                            st_next = ST_BAD;
                        end
                        else if (stat.can_append)
                        begin
                            cmd.op  = OP_APPEND;
                            st_next = ST_OK;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    KIND_FREE, KIND_COMPACT:
                    begin
                        state_next = S_RD;
                    end
                    KIND_WRITE:
                    begin
                        if (stat.addr_ok)
                        begin
                            cmd.op  = OP_BYTE_WR;
                            st_next = ST_OK;
                        end
                    end
                    KIND_READ:
                    begin
                        if (stat.addr_ok)
                        begin
                            cmd.op  = OP_BYTE_RD;
                            st_next = ST_OK;
                        end
                    end
                    default:
                    begin
                        st_next = ST_BAD;
                    end
                endcase
            end
            S_RD:
            begin
                if (stat.i_end)
                begin
                    if (stat.kind == KIND_ALLOC)
                    begin
                        st_next    = stat.fits ? ST_FULL : ST_OOM;
                        state_next = S_DONE;
                    end
                    else if (stat.kind == KIND_FREE)
                    begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_TAIL_INIT;
                        state_next = S_TAIL;
                    end
                end
                else
                begin
                    cmd.op     = OP_TBL_RD;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.kind == KIND_ALLOC)
                begin
                    if (stat.alloc_hit)
                    begin
                        cmd.op     = OP_REUSE;
                        st_next    = ST_OK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_NEXT_I;
                        state_next = S_RD;
                    end
                end
                else if (stat.kind == KIND_FREE)
                begin
                    if (stat.free_hit)
                    begin
                        state_next = S_ZERO;
                    end
                    else
                    begin
                        cmd.op     = OP_NEXT_I;
                        state_next = S_RD;
                    end
                end
                else if (stat.avail)
                begin
                    cmd.op     = OP_NEXT_I;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_MOVE;
                end
            end
            S_ZERO:
            begin
                if (stat.k_end)
                begin
                    cmd.op     = OP_MARK_FREE;
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_ZERO_SEG;
                end
            end
            S_MOVE:
            begin
                if (stat.k_end)
                begin
                    cmd.op     = OP_KEEP;
                    state_next = S_RD;
                end
                else if (stat.move_ok)
                begin
                    cmd.op     = OP_MOVE_RD;
                    state_next = S_MOVE_WR;
                end
                else
                begin
                    cmd.op = OP_SKIP_BYTE;
                end
            end
            S_MOVE_WR:
            begin
                cmd.op     = OP_MOVE_WR;
                state_next = S_MOVE;
            end
            S_TAIL:
            begin
                if (stat.tail_end)
                begin
                    cmd.op     = OP_COMPACT_END;
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_ZERO_TAIL;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

/* sv/sacu_dp.sv */
// ----------------------------------------------------------------------------
// Segment allocator datapath
// Byte store, segment table, pointers and the output register.
// ----------------------------------------------------------------------------
module sacu_dp #(
    parameter int STORE_BYTES  = 32,
    parameter int MAX_SEGMENTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [23:0]       in_data,
    input  sacu_pkg::dp_cmd_t cmd,
    output sacu_pkg::dp_stat_t stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [23:0]       out_data
);
    import sacu_pkg::*;

    localparam int BW   = $clog2(STORE_BYTES);
    localparam int FTW  = $clog2(STORE_BYTES + 1);
    localparam int IW   = $clog2(MAX_SEGMENTS);
    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int ENTW = 2 * FTW + 1;
    localparam int CMPW = FTW + 7;

    logic [2:0]             kind_reg;
    logic [5:0]             size_reg;
    logic [4:0]             addr_reg;
    logic [7:0]             wdata_reg;
    logic [FTW-1:0]         free_top_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          i_reg;
    logic [CW-1:0]          keep_reg;
    logic [FTW-1:0]         dst_reg;
    logic [FTW-1:0]         k_reg;
    logic [FTW-1:0]         res_addr_reg;
    logic [STORE_BYTES-1:0] bv_reg;
    logic                   bvq_reg;
    logic                   out_valid_reg;
    logic [2:0]             out_status_reg;
    logic [5:0]             out_addr_reg;
    logic [7:0]             out_rdata_reg;

    logic [ENTW-1:0] tq;
    logic [FTW-1:0]  e_start;
    logic [FTW-1:0]  e_size;
    logic            e_avail;
    logic [CMPW-1:0] src_sum;
    logic [CMPW-1:0] dst_sum;
    logic            src_ok;

    logic            t_wr;
    logic [IW-1:0]   t_waddr;
    logic [ENTW-1:0] t_wdata;
    logic            t_rd;
    logic            b_wr;
    logic [BW-1:0]   b_waddr;
    logic [7:0]      b_wdata;
    logic            b_rd;
    logic [BW-1:0]   b_raddr;
    logic [7:0]      bq;

    assign e_start = tq[FTW-1:0];
    assign e_size  = tq[2*FTW-1:FTW];
    assign e_avail = tq[2*FTW];
    assign src_sum = CMPW'(e_start) + CMPW'(k_reg);
    assign dst_sum = CMPW'(dst_reg) + CMPW'(k_reg);
    assign src_ok  = src_sum < CMPW'(STORE_BYTES);

    assign stat.kind       = kind_reg;
    assign stat.size_zero  = (size_reg == 6'd0);
    assign stat.fits       = (CMPW'(size_reg) + CMPW'(free_top_reg)) <= CMPW'(STORE_BYTES);
    assign stat.can_append = stat.fits && (CMPW'(count_reg) < CMPW'(MAX_SEGMENTS));
    assign stat.i_end      = (i_reg == count_reg);
    assign stat.alloc_hit  = e_avail && (CMPW'(e_size) == CMPW'(size_reg));
    assign stat.free_hit   = (CMPW'(e_start) == CMPW'(addr_reg));
    assign stat.avail      = e_avail;
    assign stat.k_end      = (k_reg == e_size);
    assign stat.move_ok    = src_ok && (dst_sum < CMPW'(STORE_BYTES));
    assign stat.tail_end   = (k_reg >= free_top_reg) || (CMPW'(k_reg) >= CMPW'(STORE_BYTES));
    assign stat.addr_ok    = CMPW'(addr_reg) < CMPW'(STORE_BYTES);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    always_comb
    begin
        t_wr    = 1'b0;
        t_waddr = i_reg[IW-1:0];
        t_wdata = tq;
        t_rd    = 1'b0;
        b_wr    = 1'b0;
        b_waddr = dst_sum[BW-1:0];
        b_wdata = bq;
        b_rd    = 1'b0;
        b_raddr = src_sum[BW-1:0];
        unique case (cmd.op)
            OP_APPEND:
            begin
                t_wr    = 1'b1;
                t_waddr = count_reg[IW-1:0];
                t_wdata = {1'b0, FTW'(size_reg), free_top_reg};
            end
            OP_TBL_RD:
            begin
                t_rd = 1'b1;
            end
            OP_REUSE:
            begin
                t_wr    = 1'b1;
                t_wdata = {1'b0, e_size, e_start};
            end
            OP_MARK_FREE:
            begin
                t_wr    = 1'b1;
                t_wdata = {1'b1, e_size, e_start};
            end
            OP_KEEP:
            begin
                t_wr    = 1'b1;
                t_waddr = keep_reg[IW-1:0];
                t_wdata = {1'b0, e_size, dst_reg};
            end
            OP_MOVE_RD:
            begin
                b_rd = 1'b1;
            end
            OP_MOVE_WR:
            begin
                b_wr = 1'b1;
            end
            OP_BYTE_WR:
            begin
                b_wr    = 1'b1;
                b_waddr = BW'(addr_reg);
                b_wdata = wdata_reg;
            end
            OP_BYTE_RD:
            begin
                b_rd    = 1'b1;
                b_raddr = BW'(addr_reg);
            end
            default:
            begin
            end
        endcase
    end

    sacu_ram #(.WIDTH(ENTW), .DEPTH(MAX_SEGMENTS)) u_table (
        .clk     (clk),
        .wr_en   (t_wr),
        .wr_addr (t_waddr),
        .wr_data (t_wdata),
        .rd_en   (t_rd),
        .rd_addr (i_reg[IW-1:0]),
        .rd_data (tq)
    );

    sacu_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .clk     (clk),
        .wr_en   (b_wr),
        .wr_addr (b_waddr),
        .wr_data (b_wdata),
        .rd_en   (b_rd),
        .rd_addr (b_raddr),
        .rd_data (bq)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            kind_reg  <= in_data[2:0];
            size_reg  <= in_data[8:3];
            addr_reg  <= in_data[13:9];
            wdata_reg <= in_data[21:14];
        end
        if (b_rd)
        begin
            bvq_reg <= bv_reg[b_raddr];
        end
        if (cmd.finish)
        begin
            out_status_reg <= cmd.status;
            out_addr_reg   <= 6'(res_addr_reg);
            out_rdata_reg  <= (kind_reg == KIND_READ && cmd.status == ST_OK && bvq_reg)
                              ? bq : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg  <= '0;
            count_reg     <= '0;
            i_reg         <= '0;
            keep_reg      <= '0;
            dst_reg       <= '0;
            k_reg         <= '0;
            res_addr_reg  <= '0;
            bv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_LOAD:
                begin
                    i_reg        <= '0;
                    keep_reg     <= '0;
                    dst_reg      <= '0;
                    k_reg        <= '0;
                    res_addr_reg <= '0;
                end
                OP_APPEND:
                begin
                    count_reg    <= count_reg + 1'b1;
                    res_addr_reg <= free_top_reg;
                    free_top_reg <= free_top_reg + FTW'(size_reg);
                end
                OP_NEXT_I:
                begin
                    i_reg <= i_reg + 1'b1;
                    k_reg <= '0;
                end
                OP_REUSE:
                begin
                    res_addr_reg <= e_start;
                end
                OP_ZERO_SEG:
                begin
                    if (src_ok)
                    begin
                        bv_reg[src_sum[BW-1:0]] <= 1'b0;
                    end
                    k_reg <= k_reg + 1'b1;
                end
                OP_MOVE_WR:
                begin
                    bv_reg[dst_sum[BW-1:0]] <= bvq_reg;
                    k_reg <= k_reg + 1'b1;
                end
                OP_SKIP_BYTE:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                OP_KEEP:
                begin
                    i_reg    <= i_reg + 1'b1;
                    keep_reg <= keep_reg + 1'b1;
                    dst_reg  <= dst_reg + e_size;
                    k_reg    <= '0;
                end
                OP_TAIL_INIT:
                begin
                    k_reg <= dst_reg;
                end
                OP_ZERO_TAIL:
                begin
                    bv_reg[k_reg[BW-1:0]] <= 1'b0;
                    k_reg <= k_reg + 1'b1;
                end
                OP_COMPACT_END:
                begin
                    count_reg    <= keep_reg;
                    free_top_reg <= dst_reg;
                    res_addr_reg <= dst_reg;
                end
                OP_BYTE_WR:
                begin
                    bv_reg[BW'(addr_reg)] <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {7'd0, out_rdata_reg, out_addr_reg, out_status_reg};

endmodule

/* sv/segment_allocator_with_compaction_unit.sv */
// ----------------------------------------------------------------------------
// Segment allocator with compaction
// Bump allocator with exact-fit reuse, free, compaction and byte access.
//
//   channel  dir  fields (tdata, low bit up)
//   s_axis   in   kind[2:0] alloc_size[8:3] address[13:9] write_data[21:14]
//   m_axis   out  status[2:0] result_address[8:3] read_data[16:9]
//
// One transaction in flight. Write, read and bad requests go from decode straight
// to the result; allocate tries the free top first, then a table scan up to the
// segment count. Free zeroes each byte of the segment; compaction moves the bytes
// of kept segments down and clears the tail bytes. Reset is
// asynchronous, active low; the byte store reads zero after reset through
// per-byte valid bits. A stalled result holds until m_tready.
// ----------------------------------------------------------------------------
module segment_allocator_with_compaction_unit #(
    parameter int STORE_BYTES  = sacu_pkg::STORE_BYTES_DEF,
    parameter int MAX_SEGMENTS = sacu_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // kind, alloc_size, address, write_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status, result_address, read_data
);
    import sacu_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sacu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sacu_dp #(
        .STORE_BYTES  (STORE_BYTES),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

/* sv/sacu_checker.sv */
// ----------------------------------------------------------------------------
// Segment allocator checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_allocator_with_compaction_unit_macros.svh"

module sacu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `SACU_IMPLY(a_out_hold, $past(m_tvalid && !m_tready) && $past(rst_n), m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `SACU_IMPLY(a_one_in_flight, s_tvalid && s_tready, ##1 !s_tready, "second transaction taken while busy")
    `SACU_IMPLY(a_status_code, m_tvalid, m_tdata[2:0] <= 3'd4, "status code out of range")
    `SACU_IMPLY(a_fail_zero, m_tvalid && m_tdata[2:0] != 3'd0, m_tdata[16:3] == 14'd0, "failed result carries data")

endmodule

bind segment_allocator_with_compaction_unit sacu_checker u_sacu_checker (.*);

/* sim/tb_segment_allocator_with_compaction_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment allocator testbench
// Drives allocate, free, compact, byte access and invalid requests over the input
// stream, predicts each response with a software model of the store and the
// segment table, and compares every returned response field by field.
// ----------------------------------------------------------------------------
class alloc_scoreboard;
    logic [7:0]  mem [32];
    logic [5:0]  seg_start [16];
    logic [5:0]  seg_size [16];
    logic        seg_avail [16];
    int          seg_cnt;
    int          top;
    logic [2:0]  exp_status [$];
    logic [5:0]  exp_addr [$];
    logic [7:0]  exp_rdata [$];
    int          errors;
    int          checked;

    function new();
        for (int i = 0; i < 32; i++) mem[i] = 8'd0;
        for (int i = 0; i < 16; i++)
        begin
            seg_start[i] = 0;
            seg_size[i] = 0;
            seg_avail[i] = 1'b0;
        end
        seg_cnt = 0;
        top = 0;
        errors = 0;
        checked = 0;
    endfunction

    function void note_request(logic [2:0] kind, logic [5:0] sz, logic [4:0] a,
                               logic [7:0] wd);
        logic [2:0] st;
        logic [5:0] ra;
        logic [7:0] rd;
        int keep;
        int dst;
        bit found;
        st = sacu_pkg::ST_BAD;
        ra = 0;
        rd = 0;
        found = 0;
        case (kind)
            sacu_pkg::KIND_ALLOC:
            begin
                if (sz != 0)
                begin
                    if (sz <= 32 - top && seg_cnt < 16)
                    begin
                        seg_start[seg_cnt] = 6'(top);
                        seg_size[seg_cnt] = sz;
                        seg_avail[seg_cnt] = 1'b0;
                        seg_cnt++;
                        ra = 6'(top);
                        top += sz;
                        st = sacu_pkg::ST_OK;
                    end
                    else
                    begin
                        for (int i = 0; i < seg_cnt && !found; i++)
                            if (seg_avail[i] && seg_size[i] == sz)
                            begin
                                seg_avail[i] = 1'b0;
                                ra = seg_start[i];
                                st = sacu_pkg::ST_OK;
                                found = 1;
                            end
                        if (!found)
                            st = (sz <= 32 - top) ? sacu_pkg::ST_FULL : sacu_pkg::ST_OOM;
                    end
                end
            end
            sacu_pkg::KIND_FREE:
            begin
                st = sacu_pkg::ST_NOTFOUND;
                for (int i = 0; i < seg_cnt && !found; i++)
                    if (seg_start[i] == a)
                    begin
                        for (int k = 0; k < seg_size[i]; k++)
                            if (seg_start[i] + k < 32) mem[seg_start[i] + k] = 0;
                        seg_avail[i] = 1'b1;
                        st = sacu_pkg::ST_OK;
                        found = 1;
                    end
            end
            sacu_pkg::KIND_COMPACT:
            begin
                keep = 0;
                dst = 0;
                for (int i = 0; i < seg_cnt; i++)
                    if (!seg_avail[i])
                    begin
                        for (int k = 0; k < seg_size[i]; k++)
                            if (seg_start[i] + k < 32 && dst + k < 32)
                                mem[dst + k] = mem[seg_start[i] + k];
                        seg_start[keep] = 6'(dst);
                        seg_size[keep] = seg_size[i];
                        seg_avail[keep] = 1'b0;
                        dst += seg_size[i];
                        keep++;
                    end
                for (int i = keep; i < 16; i++)
                begin
                    seg_start[i] = 0;
                    seg_size[i] = 0;
                    seg_avail[i] = 1'b0;
                end
                for (int k = dst; k < top && k < 32; k++) mem[k] = 0;
                seg_cnt = keep;
                top = dst;
                st = sacu_pkg::ST_OK;
                ra = 6'(top);
            end
            sacu_pkg::KIND_WRITE:
            begin
                mem[a] = wd;
                st = sacu_pkg::ST_OK;
            end
            sacu_pkg::KIND_READ:
            begin
                rd = mem[a];
                st = sacu_pkg::ST_OK;
            end
            default: ;
        endcase
        exp_status.push_back(st);
        exp_addr.push_back(ra);
        exp_rdata.push_back(rd);
    endfunction

    function int pending();
        return exp_status.size();
    endfunction

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task check_result(logic [23:0] d);
        logic [2:0] st;
        logic [5:0] ra;
        logic [7:0] rd;
        if (pending() == 0)
        begin
            report("unexpected response", d, 0);
            return;
        end
        st = exp_status.pop_front();
        ra = exp_addr.pop_front();
        rd = exp_rdata.pop_front();
        checked++;
        if (d[2:0] != st) report("status", d[2:0], st);
        if (d[8:3] != ra) report("result_address", d[8:3], ra);
        if (d[16:9] != rd) report("read_data", d[16:9], rd);
    endtask
endclass

module tb_segment_allocator_with_compaction_unit;
    import sacu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    alloc_scoreboard sb;
    int  stall_mode;
    bit  hold_on;
    int  sent;
    int  n_alloc, n_free, n_compact, n_rw;

    segment_allocator_with_compaction_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sample responses and drive the receiver's stall pattern
    initial
    begin
        m_tready = 1'b0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 1) == 0);
                default: m_tready <= 1'b0;
            endcase
        end
    end

    task automatic send_request(logic [2:0] kind, logic [5:0] sz, logic [4:0] a,
                                logic [7:0] wd);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, wd, a, sz, kind};
        do @(posedge clk); while (!s_tready);
        sb.note_request(kind, sz, a, wd);
        sent++;
        case (kind)
            KIND_ALLOC: n_alloc++;
            KIND_FREE: n_free++;
            KIND_COMPACT: n_compact++;
            default: n_rw++;
        endcase
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic random_request();
        int r;
        int i;
        logic [4:0] a;
        r = $urandom_range(0, 99);
        if (r < 30)
            send_request(KIND_ALLOC,
                6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(1, 8)),
                5'($urandom), 8'($urandom));
        else if (r < 50)
        begin
            if (sb.seg_cnt > 0 && $urandom_range(0, 4) != 0)
            begin
                i = $urandom_range(0, sb.seg_cnt - 1);
                a = 5'(sb.seg_start[i]);
            end
            else
                a = 5'($urandom);
            send_request(KIND_FREE, 6'($urandom), a, 8'($urandom));
        end
        else if (r < 57)
            send_request(KIND_COMPACT, 6'($urandom), 5'($urandom), 8'($urandom));
        else if (r < 77)
            send_request(KIND_WRITE, 6'($urandom), 5'($urandom), 8'($urandom));
        else if (r < 97)
            send_request(KIND_READ, 6'($urandom), 5'($urandom), 8'($urandom));
        else
            send_request(3'($urandom_range(5, 7)), 6'($urandom), 5'($urandom),
                         8'($urandom));
    endtask

    initial
    begin
        int burst;
        sb = new();
        sent = 0;
        n_alloc = 0;
        n_free = 0;
        n_compact = 0;
        n_rw = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(KIND_READ, 0, 5'd31, 0);
        send_request(KIND_ALLOC, 6'd0, 0, 0);
        send_request(KIND_ALLOC, 6'd63, 0, 0);
        send_request(KIND_ALLOC, 6'd33, 0, 0);
        send_request(KIND_FREE, 0, 5'd0, 0);
        send_request(KIND_ALLOC, 6'd4, 0, 0);
        send_request(KIND_ALLOC, 6'd8, 0, 0);
        send_request(KIND_WRITE, 0, 5'd0, 8'hff);
        send_request(KIND_WRITE, 0, 5'd4, 8'haa);
        send_request(KIND_WRITE, 0, 5'd31, 8'h55);
        send_request(KIND_FREE, 0, 5'd0, 0);
        send_request(KIND_FREE, 0, 5'd0, 0);
        send_request(KIND_FREE, 0, 5'd3, 0);
        send_request(KIND_ALLOC, 6'd20, 0, 0);
        send_request(KIND_ALLOC, 6'd4, 0, 0);
        send_request(KIND_FREE, 0, 5'd4, 0);
        send_request(KIND_ALLOC, 6'd8, 0, 0);
        send_request(KIND_COMPACT, 0, 0, 0);
        send_request(KIND_READ, 0, 5'd4, 0);
        send_request(3'd7, 6'h3f, 5'h1f, 8'hff);
        for (int i = 0; i < 17; i++) send_request(KIND_ALLOC, 6'd1, 0, 0);
        send_request(KIND_FREE, 0, 5'd13, 0);
        send_request(KIND_ALLOC, 6'd1, 0, 0);
        send_request(KIND_ALLOC, 6'd32, 0, 0);
        send_request(KIND_COMPACT, 0, 0, 0);

        stall_mode = 1;
        while (sent < 550)
        begin
            burst = $urandom_range(1, 20);
            if (!hold_on)
            begin
                if (sent >= 230 && sent < 400) stall_mode = 2;
                else if (sent >= 400 && sent < 450) stall_mode = 0;
                else stall_mode = 1;
            end
            repeat (burst) random_request();
            if ($urandom_range(0, 2) != 0) pause_sender();
        end
        s_tvalid <= 1'b0;
        stall_mode = 1;
        while (sb.pending() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d requests: %0d allocate, %0d free, %0d compact, %0d other",
                 sent, n_alloc, n_free, n_compact, n_rw);
        $display("%0d responses compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // long receiver hold-off counted here while the sender keeps offering
    initial
    begin
        wait (sent > 120);
        hold_on = 1'b1;
        stall_mode = 3;
        repeat (400) @(posedge clk);
        stall_mode = 1;
        hold_on = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/sacu_pkg.sv
sv/sacu_ram.sv
sv/sacu_ctrl.sv
sv/sacu_dp.sv
sv/segment_allocator_with_compaction_unit.sv
sv/sacu_checker.sv
sim/tb_segment_allocator_with_compaction_unit.sv
